### rtl/core/bir_pkg.sv
// bilinear image rescale: shared types, sizes, register indexes and clamp helpers
// depends on nothing; every other file of the block but bir_ram imports it
`timescale 1ns / 1ps

package bir_pkg;

    // sizing of the source store and the destination grid
    localparam int MAX_SRC_WIDTH  = 256;
    localparam int MAX_SRC_HEIGHT = 256;
    localparam int MAX_DST_DIM    = 2048;
    localparam int FRAC_BITS      = 16;

    // field widths of the items
    localparam int POS_W  = 11;
    localparam int CHAN_W = 8;
    localparam int PIX_W  = 3 * CHAN_W;

    // configuration register widths
    localparam int SRC_REG_W = 9;
    localparam int DST_REG_W = 12;

    // derived widths
    localparam int SRC_XW   = $clog2(MAX_SRC_WIDTH);
    localparam int SRC_YW   = $clog2(MAX_SRC_HEIGHT);
    localparam int SRC_CW   = (SRC_XW > SRC_YW) ? SRC_XW : SRC_YW;
    localparam int SW_W     = $clog2(MAX_SRC_WIDTH + 1);
    localparam int SH_W     = $clog2(MAX_SRC_HEIGHT + 1);
    localparam int DD_W     = $clog2(MAX_DST_DIM + 1);
    localparam int STEP_W   = SRC_CW + FRAC_BITS;
    localparam int DIV_W    = $clog2(MAX_DST_DIM);
    localparam int DCNT_W   = $clog2(STEP_W + 1);
    localparam int MUL_W    = POS_W + STEP_W;
    localparam int WGT_W    = FRAC_BITS + 1;
    localparam int T_W      = FRAC_BITS + CHAN_W;
    localparam int TSUM_W   = T_W + 1;
    localparam int ACC_W    = 2 * FRAC_BITS + CHAN_W + 1;

    // source store split into four banks by column and row parity
    localparam int NUM_BANKS  = 4;
    localparam int BANK_AW    = (SRC_XW - 1) + (SRC_YW - 1);
    localparam int BANK_DEPTH = 1 << BANK_AW;

    // queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QP_W        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QC_W        = $clog2(QUEUE_DEPTH + 1);

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_DST_WIDTH  = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_DST_HEIGHT = CFG_IDX_W'(3);

    // reset values of the size registers
    localparam logic [SRC_REG_W-1:0] RST_SRC_WIDTH  = SRC_REG_W'(256);
    localparam logic [SRC_REG_W-1:0] RST_SRC_HEIGHT = SRC_REG_W'(256);
    localparam logic [DST_REG_W-1:0] RST_DST_WIDTH  = DST_REG_W'(1920);
    localparam logic [DST_REG_W-1:0] RST_DST_HEIGHT = DST_REG_W'(1080);

    typedef enum logic [0:0] {
        OP_LOAD    = 1'b0,
        OP_COMPUTE = 1'b1
    } op_e;

    typedef struct packed {
        op_e                operation;
        logic [POS_W-1:0]   pos_x;
        logic [POS_W-1:0]   pos_y;
        logic [CHAN_W-1:0]  red_in;
        logic [CHAN_W-1:0]  green_in;
        logic [CHAN_W-1:0]  blue_in;
    } pixel_in_t;

    typedef struct packed {
        logic [POS_W-1:0]   out_x;
        logic [POS_W-1:0]   out_y;
        logic [CHAN_W-1:0]  red_out;
        logic [CHAN_W-1:0]  green_out;
        logic [CHAN_W-1:0]  blue_out;
    } pixel_out_t;

    typedef struct packed {
        logic [STEP_W-1:0]  step_h;
        logic [STEP_W-1:0]  step_v;
    } step_cfg_t;

    typedef struct packed {
        logic               full;
        logic               valid;
    } q_stat_t;

    // effective source width, clamped to [1, MAX_SRC_WIDTH]
    function automatic logic [SW_W-1:0] eff_src_width(input logic [SRC_REG_W-1:0] v);
        logic [SW_W-1:0] r;
        if (v == '0)
            r = SW_W'(1);
        else if (32'(v) > MAX_SRC_WIDTH)
            r = SW_W'(MAX_SRC_WIDTH);
        else
            r = SW_W'(v);
        return r;
    endfunction

    // effective source height, clamped to [1, MAX_SRC_HEIGHT]
    function automatic logic [SH_W-1:0] eff_src_height(input logic [SRC_REG_W-1:0] v);
        logic [SH_W-1:0] r;
        if (v == '0)
            r = SH_W'(1);
        else if (32'(v) > MAX_SRC_HEIGHT)
            r = SH_W'(MAX_SRC_HEIGHT);
        else
            r = SH_W'(v);
        return r;
    endfunction

    // effective destination size, clamped to [2, MAX_DST_DIM]
    function automatic logic [DD_W-1:0] eff_dst_dim(input logic [DST_REG_W-1:0] v);
        logic [DD_W-1:0] r;
        if (32'(v) < 2)
            r = DD_W'(2);
        else if (32'(v) > MAX_DST_DIM)
            r = DD_W'(MAX_DST_DIM);
        else
            r = DD_W'(v);
        return r;
    endfunction

endpackage

### rtl/core/bir_ram.sv
// generic simple dual port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module bir_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 16384
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/core/bir_front.sv
// front of the rescaler: size registers, step divider, item classification
// depends on bir_pkg
`timescale 1ns / 1ps

module bir_front (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [bir_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bir_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            pixel_valid,
    output logic                            pixel_ready,
    input  bir_pkg::pixel_in_t              pixel,
    input  bir_pkg::q_stat_t                q_stat,
    output logic                            push,
    output bir_pkg::pixel_in_t              push_item,
    output bir_pkg::step_cfg_t              steps
);

    import bir_pkg::*;

    logic [SRC_REG_W-1:0] src_w_reg, src_w_next;
    logic [SRC_REG_W-1:0] src_h_reg, src_h_next;
    logic [DST_REG_W-1:0] dst_w_reg, dst_w_next;
    logic [DST_REG_W-1:0] dst_h_reg, dst_h_next;
    logic [STEP_W-1:0]    step_h_reg, step_h_next;
    logic [STEP_W-1:0]    step_v_reg, step_v_next;
    logic                 busy_reg, busy_next;
    logic                 tgt_v_reg, tgt_v_next;
    logic [DCNT_W-1:0]    cnt_reg, cnt_next;
    logic [DIV_W-1:0]     rem_reg, rem_next;
    logic [STEP_W-1:0]    quo_reg, quo_next;
    logic [DIV_W-1:0]     den_reg, den_next;

    logic                 cfg_wr;
    logic                 is_h, is_v;
    logic [SW_W-1:0]      sw_new;
    logic [SH_W-1:0]      sh_new;
    logic [DD_W-1:0]      dw_new, dh_new;
    logic [DIV_W:0]       rem_sh;
    logic                 qbit;
    logic [SW_W-1:0]      sw_eff;
    logic [SH_W-1:0]      sh_eff;
    logic [DD_W-1:0]      dw_eff, dh_eff;
    logic                 in_range;

    assign cfg_ready   = !busy_reg;
    assign pixel_ready = !busy_reg && !q_stat.full;
    assign cfg_wr      = cfg_valid && !busy_reg;
    assign is_h        = (cfg_index == REG_SRC_WIDTH) || (cfg_index == REG_DST_WIDTH);
    assign is_v        = (cfg_index == REG_SRC_HEIGHT) || (cfg_index == REG_DST_HEIGHT);

    // register writes and the restoring divider, one quotient bit a cycle
    always_comb
    begin
        src_w_next  = src_w_reg;
        src_h_next  = src_h_reg;
        dst_w_next  = dst_w_reg;
        dst_h_next  = dst_h_reg;
        step_h_next = step_h_reg;
        step_v_next = step_v_reg;
        busy_next   = busy_reg;
        tgt_v_next  = tgt_v_reg;
        cnt_next    = cnt_reg;
        rem_next    = rem_reg;
        quo_next    = quo_reg;
        den_next    = den_reg;

        sw_new = eff_src_width((cfg_index == REG_SRC_WIDTH) ?
                               cfg_data[SRC_REG_W-1:0] : src_w_reg);
        sh_new = eff_src_height((cfg_index == REG_SRC_HEIGHT) ?
                                cfg_data[SRC_REG_W-1:0] : src_h_reg);
        dw_new = eff_dst_dim((cfg_index == REG_DST_WIDTH) ?
                             cfg_data[DST_REG_W-1:0] : dst_w_reg);
        dh_new = eff_dst_dim((cfg_index == REG_DST_HEIGHT) ?
                             cfg_data[DST_REG_W-1:0] : dst_h_reg);

        rem_sh = {rem_reg, quo_reg[STEP_W-1]};
        qbit   = (rem_sh >= {1'b0, den_reg});

        if (busy_reg)
        begin
            rem_next = qbit ? DIV_W'(rem_sh - {1'b0, den_reg}) : rem_sh[DIV_W-1:0];
            quo_next = {quo_reg[STEP_W-2:0], qbit};
            cnt_next = cnt_reg - DCNT_W'(1);
            if (cnt_reg == DCNT_W'(1))
            begin
                busy_next = 1'b0;
                if (tgt_v_reg)
                    step_v_next = {quo_reg[STEP_W-2:0], qbit};
                else
                    step_h_next = {quo_reg[STEP_W-2:0], qbit};
            end
        end
        else if (cfg_wr && (is_h || is_v))
        begin
            case (cfg_index)
                REG_SRC_WIDTH:  src_w_next = cfg_data[SRC_REG_W-1:0];
                REG_SRC_HEIGHT: src_h_next = cfg_data[SRC_REG_W-1:0];
                REG_DST_WIDTH:  dst_w_next = cfg_data[DST_REG_W-1:0];
                REG_DST_HEIGHT: dst_h_next = cfg_data[DST_REG_W-1:0];
                default:        src_w_next = src_w_reg;
            endcase
            busy_next  = 1'b1;
            tgt_v_next = is_v;
            cnt_next   = DCNT_W'(STEP_W);
            rem_next   = '0;
            if (is_v)
            begin
                quo_next = {SRC_CW'(sh_new - SH_W'(1)), {FRAC_BITS{1'b0}}};
                den_next = DIV_W'(dh_new - DD_W'(1));
            end
            else
            begin
                quo_next = {SRC_CW'(sw_new - SW_W'(1)), {FRAC_BITS{1'b0}}};
                den_next = DIV_W'(dw_new - DD_W'(1));
            end
        end
    end

    // control and configuration state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_w_reg  <= RST_SRC_WIDTH;
            src_h_reg  <= RST_SRC_HEIGHT;
            dst_w_reg  <= RST_DST_WIDTH;
            dst_h_reg  <= RST_DST_HEIGHT;
            step_h_reg <= '0;
            step_v_reg <= '0;
            busy_reg   <= 1'b0;
            tgt_v_reg  <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            src_w_reg  <= src_w_next;
            src_h_reg  <= src_h_next;
            dst_w_reg  <= dst_w_next;
            dst_h_reg  <= dst_h_next;
            step_h_reg <= step_h_next;
            step_v_reg <= step_v_next;
            busy_reg   <= busy_next;
            tgt_v_reg  <= tgt_v_next;
            cnt_reg    <= cnt_next;
        end
    end

    // divider datapath
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    // classify: out-of-range loads and requests are dropped here
    always_comb
    begin
        sw_eff = eff_src_width(src_w_reg);
        sh_eff = eff_src_height(src_h_reg);
        dw_eff = eff_dst_dim(dst_w_reg);
        dh_eff = eff_dst_dim(dst_h_reg);
        if (pixel.operation == OP_LOAD)
            in_range = (32'(pixel.pos_x) < 32'(sw_eff)) && (32'(pixel.pos_y) < 32'(sh_eff));
        else
            in_range = (32'(pixel.pos_x) < 32'(dw_eff)) && (32'(pixel.pos_y) < 32'(dh_eff));
    end

    assign push         = pixel_valid && pixel_ready && in_range;
    assign push_item    = pixel;
    assign steps.step_h = step_h_reg;
    assign steps.step_v = step_v_reg;

endmodule

### rtl/core/bir_queue.sv
// short item queue between the front and the back of the rescaler
// depends on bir_pkg
`timescale 1ns / 1ps

module bir_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  bir_pkg::pixel_in_t push_item,
    input  logic               pop,
    output bir_pkg::pixel_in_t head,
    output bir_pkg::q_stat_t   q_stat
);

    import bir_pkg::*;

    pixel_in_t         slot_reg [QUEUE_DEPTH];
    logic [QP_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QP_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QC_W-1:0]   count_reg, count_next;
    logic              do_push, do_pop;

    assign q_stat.full  = (count_reg == QC_W'(QUEUE_DEPTH));
    assign q_stat.valid = (count_reg != '0);
    assign do_push      = push && !q_stat.full;
    assign do_pop       = pop && q_stat.valid;
    assign head         = slot_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == QP_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + QP_W'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == QP_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + QP_W'(1);
        if (do_push && !do_pop)
            count_next = count_reg + QC_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - QC_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // item storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

### rtl/core/bir_back.sv
// back of the rescaler: coordinate mapping, banked source store, interpolation
// depends on bir_pkg and bir_ram
`timescale 1ns / 1ps

module bir_back (
    input  logic               clk,
    input  logic               rst_n,
    input  bir_pkg::step_cfg_t steps,
    input  bir_pkg::pixel_in_t head,
    input  bir_pkg::q_stat_t   q_stat,
    output logic               pop,
    output logic               result_valid,
    input  logic               result_ready,
    output bir_pkg::pixel_out_t result
);

    import bir_pkg::*;

    localparam logic [WGT_W-1:0] ONE = WGT_W'(1) << FRAC_BITS;

    logic                 advance;

    // stage a: scaled coordinates
    logic                 a_valid_reg;
    op_e                  a_op_reg;
    logic [POS_W-1:0]     a_px_reg, a_py_reg;
    logic [PIX_W-1:0]     a_pix_reg;
    logic [MUL_W-1:0]     a_fx_reg, a_fy_reg;

    // stage b: store access under way
    logic                 b_valid_reg;
    logic [POS_W-1:0]     b_px_reg, b_py_reg;
    logic [FRAC_BITS-1:0] b_dx_reg, b_dy_reg;
    logic                 b_xs_reg, b_ys_reg;

    // stage c: horizontal blends
    logic                 c_valid_reg;
    logic [POS_W-1:0]     c_px_reg, c_py_reg;
    logic [FRAC_BITS-1:0] c_dy_reg;
    logic [T_W-1:0]       c_t1_reg [3];
    logic [T_W-1:0]       c_t2_reg [3];

    logic                 out_valid_reg;
    pixel_out_t           out_reg;

    logic [SRC_XW-1:0]    x0, x1;
    logic [SRC_YW-1:0]    y0, y1;
    logic [FRAC_BITS-1:0] dx, dy;
    logic                 is_load;
    logic [BANK_AW-1:0]   waddr;
    logic [BANK_AW-1:0]   raddr [NUM_BANKS];
    logic                 we [NUM_BANKS];
    logic [PIX_W-1:0]     rd_data [NUM_BANKS];

    logic [PIX_W-1:0]     n1, n2, n3, n4;
    logic [WGT_W-1:0]     wdx, iwdx, wdy, iwdy;
    logic [TSUM_W-1:0]    tsum1, tsum2;
    logic [T_W-1:0]       t1_next [3];
    logic [T_W-1:0]       t2_next [3];
    logic [ACC_W-1:0]     acc;
    logic [CHAN_W-1:0]    v [3];

    assign advance      = !out_valid_reg || result_ready;
    assign pop          = advance && q_stat.valid;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    // stage a: map destination position into the source grid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            a_valid_reg   <= q_stat.valid;
            b_valid_reg   <= a_valid_reg && (a_op_reg == OP_COMPUTE);
            c_valid_reg   <= b_valid_reg;
            out_valid_reg <= c_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            a_op_reg  <= head.operation;
            a_px_reg  <= head.pos_x;
            a_py_reg  <= head.pos_y;
            a_pix_reg <= {head.red_in, head.green_in, head.blue_in};
            a_fx_reg  <= MUL_W'(head.pos_x) * MUL_W'(steps.step_h);
            a_fy_reg  <= MUL_W'(head.pos_y) * MUL_W'(steps.step_v);
        end
    end

    // stage b: integer and fraction parts, bank addresses
    always_comb
    begin
        x0      = a_fx_reg[FRAC_BITS +: SRC_XW];
        y0      = a_fy_reg[FRAC_BITS +: SRC_YW];
        dx      = a_fx_reg[FRAC_BITS-1:0];
        dy      = a_fy_reg[FRAC_BITS-1:0];
        x1      = x0 + SRC_XW'(1);
        y1      = y0 + SRC_YW'(1);
        is_load = a_valid_reg && (a_op_reg == OP_LOAD);
        waddr   = {a_py_reg[SRC_YW-1:1], a_px_reg[SRC_XW-1:1]};
    end

    // four banks so that all four neighbours come out in one access
    for (genvar b = 0; b < NUM_BANKS; b++)
    begin : g_bank
        localparam logic XP = ((b % 2) == 1);
        localparam logic YP = (b >= 2);
        logic [SRC_XW-1:0] cx;
        logic [SRC_YW-1:0] cy;

        assign cx       = (x0[0] == XP) ? x0 : x1;
        assign cy       = (y0[0] == YP) ? y0 : y1;
        assign raddr[b] = {cy[SRC_YW-1:1], cx[SRC_XW-1:1]};
        assign we[b]    = advance && is_load &&
                          (a_px_reg[0] == XP) && (a_py_reg[0] == YP);

        bir_ram #(
            .WIDTH (PIX_W),
            .DEPTH (BANK_DEPTH)
        ) u_bank (
            .clk   (clk),
            .we    (we[b]),
            .waddr (waddr),
            .wdata (a_pix_reg),
            .re    (advance),
            .raddr (raddr[b]),
            .rdata (rd_data[b])
        );
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            b_px_reg <= a_px_reg;
            b_py_reg <= a_py_reg;
            b_dx_reg <= dx;
            b_dy_reg <= dy;
            b_xs_reg <= x0[0];
            b_ys_reg <= y0[0];
        end
    end

    // stage c: pick neighbours, blend along the row
    always_comb
    begin
        n1 = rd_data[{b_ys_reg, b_xs_reg}];
        n2 = (b_dx_reg != '0) ? rd_data[{b_ys_reg, !b_xs_reg}] : n1;
        n3 = (b_dy_reg != '0) ? rd_data[{!b_ys_reg, b_xs_reg}] : n1;
        if (b_dx_reg == '0)
            n4 = n3;
        else if (b_dy_reg == '0)
            n4 = n2;
        else
            n4 = rd_data[{!b_ys_reg, !b_xs_reg}];
        wdx  = {1'b0, b_dx_reg};
        iwdx = ONE - wdx;
        tsum1 = '0;
        tsum2 = '0;
        for (int c = 0; c < 3; c++)
        begin
            tsum1 = TSUM_W'(wdx) * TSUM_W'(n2[PIX_W-1-CHAN_W*c -: CHAN_W]) +
                    TSUM_W'(iwdx) * TSUM_W'(n1[PIX_W-1-CHAN_W*c -: CHAN_W]);
            tsum2 = TSUM_W'(wdx) * TSUM_W'(n4[PIX_W-1-CHAN_W*c -: CHAN_W]) +
                    TSUM_W'(iwdx) * TSUM_W'(n3[PIX_W-1-CHAN_W*c -: CHAN_W]);
            t1_next[c] = tsum1[T_W-1:0];
            t2_next[c] = tsum2[T_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            c_px_reg <= b_px_reg;
            c_py_reg <= b_py_reg;
            c_dy_reg <= b_dy_reg;
            c_t1_reg <= t1_next;
            c_t2_reg <= t2_next;
        end
    end

    // output stage: blend the two rows and truncate
    always_comb
    begin
        wdy  = {1'b0, c_dy_reg};
        iwdy = ONE - wdy;
        acc  = '0;
        for (int c = 0; c < 3; c++)
        begin
            acc  = ACC_W'(wdy) * ACC_W'(c_t2_reg[c]) + ACC_W'(iwdy) * ACC_W'(c_t1_reg[c]);
            v[c] = acc[2*FRAC_BITS +: CHAN_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg.out_x     <= c_px_reg;
            out_reg.out_y     <= c_py_reg;
            out_reg.red_out   <= v[0];
            out_reg.green_out <= v[1];
            out_reg.blue_out  <= v[2];
        end
    end

endmodule

### rtl/core/bilinear_image_rescale.sv
// channel   | direction | handshake                | payload
// pixel     | in        | pixel_valid/pixel_ready  | pixel_in_t: load or compute item
// result    | out       | result_valid/result_ready| pixel_out_t: interpolated pixel
// cfg       | in        | cfg_valid/cfg_ready      | cfg_index, cfg_data
//
// one item a cycle sustained while the divider is idle and result_ready is high; accepted
// compute items go through the queue, then the multiply, banked store read and row blend
// stages, with the column blend feeding the output register.
// a size register write runs the restoring step divider; both pixel and cfg
// ready stay low while it runs. reset clears control only, no clearing pass: the
// source store is undefined until loaded. a stalled result holds the whole back end,
// and the two-entry queue then fills and drops pixel_ready.
//
// top level of the bilinear rescaler; depends on bir_pkg, bir_front, bir_queue, bir_back
`timescale 1ns / 1ps

module bilinear_image_rescale (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [bir_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bir_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            pixel_valid,
    output logic                            pixel_ready,
    input  bir_pkg::pixel_in_t              pixel,
    output logic                            result_valid,
    input  logic                            result_ready,
    output bir_pkg::pixel_out_t             result
);

    import bir_pkg::*;

    logic       push;
    logic       pop;
    pixel_in_t  push_item;
    pixel_in_t  head;
    q_stat_t    q_stat;
    step_cfg_t  steps;

    // registers, step divider and classification
    bir_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .pixel_valid (pixel_valid),
        .pixel_ready (pixel_ready),
        .pixel       (pixel),
        .q_stat      (q_stat),
        .push        (push),
        .push_item   (push_item),
        .steps       (steps)
    );

    // item queue between the two halves
    bir_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head      (head),
        .q_stat    (q_stat)
    );

    // store and interpolation pipeline
    bir_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .steps        (steps),
        .head         (head),
        .q_stat       (q_stat),
        .pop          (pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

`ifndef SYNTH
    // a size write starts the divider, which blocks both inputs
    a_cfg_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_valid && cfg_ready && ((cfg_index == REG_SRC_WIDTH) ||
         (cfg_index == REG_SRC_HEIGHT) || (cfg_index == REG_DST_WIDTH) ||
         (cfg_index == REG_DST_HEIGHT))) |=> (!cfg_ready && !pixel_ready))
        else $error("size write did not start the step divider");

    // the front never pushes into a full queue
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_stat.full)
        else $error("item pushed into full queue");

    // the back only pops when an item is waiting
    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> q_stat.valid)
        else $error("pop from empty queue");
`endif

endmodule

### sim/tb_top.sv
// testbench for the bilinear rescaler: drives loads, computes and size writes,
// predicts each interpolated pixel and checks it; depends on bir_pkg and the rtl
`timescale 1ns / 1ps

module tb_top;
    import bir_pkg::*;

    localparam int RUN_LIMIT = 400000;
    localparam int DRAIN_WAIT = 10;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  pixel_valid = 1'b0;
    logic                  pixel_ready;
    pixel_in_t             pixel = '0;
    logic                  result_valid;
    logic                  result_ready = 1'b0;
    pixel_out_t            result;

    // mirror of the block state
    logic [PIX_W-1:0]  src_img [MAX_SRC_WIDTH*MAX_SRC_HEIGHT];
    bit                loaded  [MAX_SRC_WIDTH*MAX_SRC_HEIGHT];
    longint unsigned   src_w_reg, src_h_reg, dst_w_reg, dst_h_reg;
    longint unsigned   step_h, step_v;

    pixel_out_t        pending_pixels[$];
    int                errors = 0;
    int                n_items = 0;
    int                n_results = 0;
    int                n_cfg = 0;
    int                cycles = 0;
    bit                quiet = 1'b0;
    int                hold_request = 0;
    int                hold_cnt = 0;
    int                stall_cnt = 0;

    bilinear_image_rescale u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .pixel_valid  (pixel_valid),
        .pixel_ready  (pixel_ready),
        .pixel        (pixel),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    always #1 clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > RUN_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles,
                     pending_pixels.size());
            $display("FAIL");
            $finish;
        end
    end

    function automatic longint unsigned clampv(longint unsigned v, longint unsigned lo,
                                               longint unsigned hi);
        if (v < lo)
            return lo;
        if (v > hi)
            return hi;
        return v;
    endfunction

    function automatic longint unsigned derive_step(longint unsigned s, longint unsigned d);
        return ((s - 1) << FRAC_BITS) / (d - 1);
    endfunction

    function automatic void reset_mirror();
        foreach (loaded[i])
            loaded[i] = 1'b0;
        step_h = 0;
        step_v = 0;
        src_w_reg = 256;
        src_h_reg = 256;
        dst_w_reg = 1920;
        dst_h_reg = 1080;
    endfunction

    function automatic void apply_size_write(logic [CFG_IDX_W-1:0] idx,
                                             logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_SRC_WIDTH:  src_w_reg = data & 12'h1FF;
            REG_SRC_HEIGHT: src_h_reg = data & 12'h1FF;
            REG_DST_WIDTH:  dst_w_reg = data;
            REG_DST_HEIGHT: dst_h_reg = data;
            default: return;
        endcase
        if (idx == REG_SRC_WIDTH || idx == REG_DST_WIDTH)
            step_h = derive_step(clampv(src_w_reg, 1, MAX_SRC_WIDTH),
                                 clampv(dst_w_reg, 2, MAX_DST_DIM));
        else
            step_v = derive_step(clampv(src_h_reg, 1, MAX_SRC_HEIGHT),
                                 clampv(dst_h_reg, 2, MAX_DST_DIM));
    endfunction

    function automatic bit dst_in_range(longint unsigned x, longint unsigned y);
        return x < clampv(dst_w_reg, 2, MAX_DST_DIM) && y < clampv(dst_h_reg, 2, MAX_DST_DIM);
    endfunction

    // true when all four neighbours of a destination pixel have been loaded
    function automatic bit neighbours_loaded(longint unsigned x, longint unsigned y);
        longint unsigned fx, fy, x0, y0, x1, y1;
        fx = x * step_h;
        fy = y * step_v;
        x0 = fx >> FRAC_BITS;
        y0 = fy >> FRAC_BITS;
        x1 = (fx[FRAC_BITS-1:0] != 0) ? x0 + 1 : x0;
        y1 = (fy[FRAC_BITS-1:0] != 0) ? y0 + 1 : y0;
        return loaded[y0*MAX_SRC_WIDTH+x0] && loaded[y0*MAX_SRC_WIDTH+x1] &&
               loaded[y1*MAX_SRC_WIDTH+x0] && loaded[y1*MAX_SRC_WIDTH+x1];
    endfunction

    // apply one accepted item to the mirror and queue the pixel it yields
    function automatic void predict_pixel(pixel_in_t it);
        longint unsigned px, py, fx, fy, x0, y0, x1, y1, dx, dy, t1, t2, v;
        longint unsigned one;
        logic [PIX_W-1:0] n1, n2, n3, n4;
        pixel_out_t o;
        px = it.pos_x;
        py = it.pos_y;
        one = longint'(1) << FRAC_BITS;
        if (it.operation == OP_LOAD)
        begin
            if (px < clampv(src_w_reg, 1, MAX_SRC_WIDTH) &&
                py < clampv(src_h_reg, 1, MAX_SRC_HEIGHT))
            begin
                src_img[py*MAX_SRC_WIDTH+px] = {it.red_in, it.green_in, it.blue_in};
                loaded[py*MAX_SRC_WIDTH+px] = 1'b1;
            end
            return;
        end
        if (!dst_in_range(px, py))
            return;
        fx = px * step_h;
        fy = py * step_v;
        x0 = fx >> FRAC_BITS;
        y0 = fy >> FRAC_BITS;
        dx = fx & (one - 1);
        dy = fy & (one - 1);
        x1 = (dx != 0) ? x0 + 1 : x0;
        y1 = (dy != 0) ? y0 + 1 : y0;
        n1 = src_img[y0*MAX_SRC_WIDTH+x0];
        n2 = src_img[y0*MAX_SRC_WIDTH+x1];
        n3 = src_img[y1*MAX_SRC_WIDTH+x0];
        n4 = src_img[y1*MAX_SRC_WIDTH+x1];
        o.out_x = it.pos_x;
        o.out_y = it.pos_y;
        for (int c = 0; c < 3; c++)
        begin
            int sh;
            sh = 16 - 8 * c;
            t1 = dx * ((n2 >> sh) & 8'hFF) + (one - dx) * ((n1 >> sh) & 8'hFF);
            t2 = dx * ((n4 >> sh) & 8'hFF) + (one - dx) * ((n3 >> sh) & 8'hFF);
            v = (dy * t2 + (one - dy) * t1) >> (2 * FRAC_BITS);
            case (c)
                0: o.red_out = v[7:0];
                1: o.green_out = v[7:0];
                default: o.blue_out = v[7:0];
            endcase
        end
        pending_pixels.push_back(o);
    endfunction

    // result side: random stalls, long hold-off on request, and checking
    always @(posedge clk)
    begin
        pixel_out_t exp_pix;
        if (rst_n && result_valid && result_ready)
        begin
            n_results++;
            if (pending_pixels.size() == 0)
            begin
                errors++;
                $display("%0t unexpected result: got %h", $time, result);
            end
            else
            begin
                exp_pix = pending_pixels.pop_front();
                if (result.out_x !== exp_pix.out_x || result.out_y !== exp_pix.out_y ||
                    result.red_out !== exp_pix.red_out ||
                    result.green_out !== exp_pix.green_out ||
                    result.blue_out !== exp_pix.blue_out)
                begin
                    errors++;
                    $display("%0t mismatch: expected x=%0d y=%0d rgb=%h %h %h", $time,
                             exp_pix.out_x, exp_pix.out_y, exp_pix.red_out,
                             exp_pix.green_out, exp_pix.blue_out);
                    $display("%0t           actual   x=%0d y=%0d rgb=%h %h %h", $time,
                             result.out_x, result.out_y, result.red_out,
                             result.green_out, result.blue_out);
                end
            end
            stall_cnt = (quiet || $urandom_range(0, 1)) ? 0 : $urandom_range(0, 19);
        end
        if (hold_request != 0)
        begin
            hold_cnt = hold_request;
            hold_request = 0;
        end
        if (hold_cnt != 0)
            hold_cnt--;
        else if (stall_cnt != 0)
            stall_cnt--;
        result_ready <= rst_n && hold_cnt == 0 && stall_cnt == 0;
    end

    // send one item with a random gap ahead of it
    task automatic send_pixel(pixel_in_t it);
        int gap;
        gap = (quiet || $urandom_range(0, 1)) ? 0 : $urandom_range(0, 19);
        if (gap != 0)
        begin
            pixel_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pixel <= it;
        pixel_valid <= 1'b1;
        do
            @(posedge clk);
        while (!pixel_ready);
        predict_pixel(it);
        n_items++;
    endtask

    task automatic send_load(int x, int y);
        pixel_in_t it;
        it.operation = OP_LOAD;
        it.pos_x = POS_W'(x);
        it.pos_y = POS_W'(y);
        it.red_in = CHAN_W'($urandom);
        it.green_in = CHAN_W'($urandom);
        it.blue_in = CHAN_W'($urandom);
        send_pixel(it);
    endtask

    // a compute is sent only if it cannot read an unloaded source entry
    task automatic try_compute(int x, int y);
        pixel_in_t it;
        it = '0;
        it.operation = OP_COMPUTE;
        it.pos_x = POS_W'(x);
        it.pos_y = POS_W'(y);
        it.red_in = CHAN_W'($urandom);
        it.green_in = CHAN_W'($urandom);
        it.blue_in = CHAN_W'($urandom);
        if (!dst_in_range(it.pos_x, it.pos_y) || neighbours_loaded(it.pos_x, it.pos_y))
            send_pixel(it);
    endtask

    // wait until every queued pixel has come out and the pipe is empty
    task automatic drain();
        pixel_valid <= 1'b0;
        @(posedge clk);
        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_size(logic [CFG_IDX_W-1:0] idx, int value);
        cfg_index <= idx;
        cfg_data <= CFG_DATA_W'(value);
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        apply_size_write(idx, CFG_DATA_W'(value));
        n_cfg++;
        @(posedge clk);
    endtask

    // steps are zero after reset: every compute returns source pixel (0,0)
    task automatic test_reset_state();
        pixel_in_t it;
        it = {OP_LOAD, 11'd0, 11'd0, 8'hFF, 8'h00, 8'hFF};
        send_pixel(it);
        try_compute(0, 0);
        try_compute(1919, 1079);
        try_compute(1920, 0);
        try_compute(0, 1080);
        try_compute(2047, 2047);
        it = {OP_LOAD, 11'd2047, 11'd2047, 8'h00, 8'hFF, 8'h00};
        send_pixel(it);
        it = {OP_LOAD, 11'd255, 11'd255, 8'h00, 8'h00, 8'h00};
        send_pixel(it);
        try_compute(1024, 512);
        drain();
    endtask

    // clamping of size values and writes to unknown indexes
    task automatic test_size_clamps();
        write_size(REG_SRC_WIDTH, 0);
        write_size(REG_SRC_HEIGHT, 12'h1FF);
        write_size(REG_DST_WIDTH, 1);
        write_size(REG_DST_HEIGHT, 12'hFFF);
        write_size(CFG_IDX_W'(4), 7);
        write_size(CFG_IDX_W'(7), 12'hFFF);
        for (int y = 0; y < 4; y++)
            send_load(0, y);
        send_load(1, 0);
        for (int y = 0; y < 40; y += 5)
            try_compute(y % 2, y);
        try_compute(2, 0);
        try_compute(0, 2047);
        drain();
        write_size(REG_DST_WIDTH, 0);
        write_size(REG_SRC_WIDTH, 300);
        send_load(255, 0);
        try_compute(1, 0);
        drain();
    endtask

    // hold the result side for a long stretch so the block stalls its input
    task automatic test_backpressure();
        write_size(REG_SRC_WIDTH, 4);
        write_size(REG_SRC_HEIGHT, 4);
        write_size(REG_DST_WIDTH, 9);
        write_size(REG_DST_HEIGHT, 7);
        for (int i = 0; i < 16; i++)
            send_load(i % 4, i / 4);
        quiet = 1'b1;
        hold_request = 200;
        for (int i = 0; i < 30; i++)
            try_compute($urandom_range(0, 8), $urandom_range(0, 6));
        quiet = 1'b0;
        drain();
    endtask

    task automatic load_whole_source(int sw, int sh);
        int order[$];
        int j, t;
        for (int i = 0; i < sw * sh; i++)
            order.push_back(i);
        for (int i = order.size() - 1; i > 0; i--)
        begin
            j = $urandom_range(0, i);
            t = order[i];
            order[i] = order[j];
            order[j] = t;
        end
        foreach (order[i])
            send_load(order[i] % sw, order[i] / sw);
    endtask

    // phases of sizes, two fixed extremes then random: load the whole source, then mostly valid computes
    task automatic test_random_phases();
        int sw, sh, dw, dh, kind;
        pixel_in_t it;
        for (int phase = 0; phase < 2 || n_items < 800; phase++)
        begin
            if (phase == 0)
            begin
                sw = 256; sh = 1; dw = 2048; dh = 2;
            end
            else if (phase == 1)
            begin
                sw = 1; sh = 256; dw = 2; dh = 2048;
            end
            else
            begin
                sw = $urandom_range(1, 8);
                sh = $urandom_range(1, 8);
                dw = $urandom_range(0, 3) == 0 ? $urandom_range(2, 2048) : $urandom_range(2, 40);
                dh = $urandom_range(0, 3) == 0 ? $urandom_range(2, 2048) : $urandom_range(2, 40);
            end
            quiet = (phase % 4 == 3);
            write_size(REG_SRC_WIDTH, sw);
            write_size(REG_DST_WIDTH, dw);
            write_size(REG_SRC_HEIGHT, sh);
            write_size(REG_DST_HEIGHT, dh);
            load_whole_source(sw, sh);
            for (int i = 0; i < 60; i++)
            begin
                kind = $urandom_range(0, 9);
                if (kind == 0)
                begin
                    it = pixel_in_t'({$urandom, $urandom});
                    it.operation = OP_LOAD;
                    send_pixel(it);
                end
                else if (kind == 1)
                    try_compute($urandom_range(0, 2047), $urandom_range(0, 2047));
                else if (kind == 2)
                    try_compute(dw - 1, dh - 1);
                else
                    try_compute($urandom_range(0, dw - 1), $urandom_range(0, dh - 1));
            end
            drain();
        end
        quiet = 1'b0;
    endtask

    initial
    begin
        reset_mirror();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_state();
        test_size_clamps();
        test_backpressure();
        test_random_phases();
        drain();
        $display("covered %0d items, %0d interpolated pixels, %0d size writes", n_items,
                 n_results, n_cfg);
        $display("including clamped sizes, ignored positions and a long output stall");
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
